// ===== rtl/svr_pkg.sv =====
// Shared types, codes and constants for the servo slew-rate ramp block.
package svr_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 4;

  localparam int unsigned NCH = 3;
  localparam int unsigned NDUTY = 4;
  localparam int unsigned TICK_W = 17;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // angle operand of the duty multiplier
  localparam int unsigned FULL_W = 9 + ANGLE_FRAC_BITS;
  localparam int unsigned MUL_A_W = (FULL_W > 13) ? FULL_W : 13;
  localparam int unsigned PROD_W = 16 + MUL_A_W;

  localparam int unsigned PADDR_W = 5;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_TARGET = 2'd1;
  localparam logic [1:0] ACT_ANGLE  = 2'd2;
  localparam logic [1:0] ACT_RAW    = 2'd3;

  localparam logic [1:0] CH_ARM   = 2'd0;
  localparam logic [1:0] CH_WRIST = 2'd1;
  localparam logic [1:0] CH_CAM   = 2'd2;
  localparam logic [1:0] CH_AUX   = 2'd3;

  localparam logic [2:0] REG_ARM_STEP      = 3'd0;
  localparam logic [2:0] REG_ARM_MIN       = 3'd1;
  localparam logic [2:0] REG_ARM_ANGLE_MAX = 3'd2;
  localparam logic [2:0] REG_CAM_STEP      = 3'd3;
  localparam logic [2:0] REG_CAM_MIN       = 3'd4;
  localparam logic [2:0] REG_ARM_INTERVAL  = 3'd5;
  localparam logic [2:0] REG_WRIST_INTERVAL = 3'd6;
  localparam logic [2:0] REG_CAM_INTERVAL  = 3'd7;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         channel;
    logic [12:0]        angle;
    logic signed [15:0] raw_value;
  } in_t;

  typedef struct packed {
    logic [15:0] duty_arm;
    logic [15:0] duty_wrist;
    logic [15:0] duty_cam;
    logic [15:0] duty_aux;
    logic        moving_arm;
    logic        moving_wrist;
    logic        moving_cam;
    logic        settled_arm;
    logic        settled_wrist;
    logic        settled_cam;
  } out_t;

endpackage

// ===== rtl/servo_slew_rate_ramp_top.sv =====
// Servo duty generator with three ramp channels, of which only arm and camera take targets, and one raw-only output.
// Path from input beat to result beat: input register, then result register.
// Throughput: one beat per cycle while the output is not stalled; the channel update and the shared duty multiplier
// sit in one combinational pass between the two registers.
// Reset: asynchronous, active low; all duty, ramp and handshake state clears,
// intervals reset to 10 and the arm full-scale angle to 180.
module servo_slew_rate_ramp_top import svr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_t               out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] arm_step_q, arm_min_q, cam_step_q, cam_min_q;
  logic [8:0]  arm_angle_max_q;
  logic [15:0] interval_q [NCH];

  logic              s1_valid_q;
  in_t               s1_q;
  logic              out_valid_q;
  out_t              out_data_q;

  logic [15:0]       cur_q [NCH];
  logic [15:0]       cur_d [NCH];
  logic [15:0]       tgt_q [NCH];
  logic [15:0]       tgt_d [NCH];
  logic [TICK_W-1:0] ticks_q [NCH];
  logic [TICK_W-1:0] ticks_d [NCH];
  logic [NCH-1:0]    mov_q, mov_d;
  logic [15:0]       duty_q [NDUTY];
  logic [15:0]       duty_d [NDUTY];
  logic [NCH-1:0]    settled;

  logic              adv, in_acc, cfg_wr, work;
  logic [2:0]        cfg_idx;
  logic [MUL_A_W-1:0] full_ang, in_ang, arm_a, mul_a;
  logic [15:0]       mul_step, min_sel, conv_duty;
  logic [PROD_W-1:0] prod;
  logic [TICK_W-1:0] tick_inc;
  logic [15:0]       raw_mag;
  out_t              res;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign work       = s1_valid_q && adv;

  always_comb begin
    case (cfg_idx)
      REG_ARM_STEP:       prdata = {16'd0, arm_step_q};
      REG_ARM_MIN:        prdata = {16'd0, arm_min_q};
      REG_ARM_ANGLE_MAX:  prdata = {23'd0, arm_angle_max_q};
      REG_CAM_STEP:       prdata = {16'd0, cam_step_q};
      REG_CAM_MIN:        prdata = {16'd0, cam_min_q};
      REG_ARM_INTERVAL:   prdata = {16'd0, interval_q[0]};
      REG_WRIST_INTERVAL: prdata = {16'd0, interval_q[1]};
      REG_CAM_INTERVAL:   prdata = {16'd0, interval_q[2]};
      default:            prdata = 32'd0;
    endcase
  end

  // shared angle-to-duty conversion; arm angle is inverted and floors at zero
  always_comb begin
    full_ang  = MUL_A_W'(arm_angle_max_q) << ANGLE_FRAC_BITS;
    in_ang    = MUL_A_W'(s1_q.angle);
    arm_a     = (full_ang > in_ang) ? full_ang - in_ang : '0;
    mul_a     = (s1_q.channel == CH_ARM) ? arm_a : in_ang;
    mul_step  = (s1_q.channel == CH_ARM) ? arm_step_q : cam_step_q;
    min_sel   = (s1_q.channel == CH_ARM) ? arm_min_q : cam_min_q;
    prod      = PROD_W'(mul_step) * PROD_W'(mul_a);
    conv_duty = prod[ANGLE_FRAC_BITS+15:ANGLE_FRAC_BITS] + min_sel;
    raw_mag   = s1_q.raw_value[15] ? 16'(-s1_q.raw_value) : 16'(s1_q.raw_value);
  end

  always_comb begin
    cur_d   = cur_q;
    tgt_d   = tgt_q;
    ticks_d = ticks_q;
    mov_d   = mov_q;
    duty_d  = duty_q;
    settled = '0;
    tick_inc = '0;
    if (work) begin
      case (s1_q.action)
        ACT_TICK: begin
          for (int i = 0; i < NCH; i++) begin
            tick_inc = (ticks_q[i] == TICK_MAX) ? ticks_q[i] : ticks_q[i] + 1'b1;
            ticks_d[i] = tick_inc;
            if (cur_q[i] != tgt_q[i]) begin
              mov_d[i]  = 1'b1;
              duty_d[i] = cur_q[i];
              if (tick_inc > TICK_W'(interval_q[i])) begin
                ticks_d[i] = '0;
                cur_d[i] = (cur_q[i] < tgt_q[i]) ? cur_q[i] + 1'b1 : cur_q[i] - 1'b1;
              end
            end else if (mov_q[i]) begin
              mov_d[i]   = 1'b0;
              settled[i] = 1'b1;
            end
          end
        end
        ACT_TARGET: begin
          if (s1_q.channel == CH_ARM || s1_q.channel == CH_CAM) begin
            tgt_d[s1_q.channel]   = conv_duty;
            ticks_d[s1_q.channel] = '0;
          end
        end
        ACT_ANGLE: begin
          if (s1_q.channel == CH_ARM || s1_q.channel == CH_CAM) begin
            duty_d[s1_q.channel] = conv_duty;
          end else begin
            duty_d[s1_q.channel] = '0;
          end
        end
        ACT_RAW: begin
          duty_d[s1_q.channel] = raw_mag;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res.duty_arm      = duty_d[CH_ARM];
    res.duty_wrist    = duty_d[CH_WRIST];
    res.duty_cam      = duty_d[CH_CAM];
    res.duty_aux      = duty_d[CH_AUX];
    res.moving_arm    = mov_d[0];
    res.moving_wrist  = mov_d[1];
    res.moving_cam    = mov_d[2];
    res.settled_arm   = settled[0];
    res.settled_wrist = settled[1];
    res.settled_cam   = settled[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_step_q      <= '0;
      arm_min_q       <= '0;
      arm_angle_max_q <= 9'd180;
      cam_step_q      <= '0;
      cam_min_q       <= '0;
      for (int i = 0; i < NCH; i++) interval_q[i] <= 16'd10;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ARM_STEP:       arm_step_q      <= pwdata[15:0];
        REG_ARM_MIN:        arm_min_q       <= pwdata[15:0];
        REG_ARM_ANGLE_MAX:  arm_angle_max_q <= pwdata[8:0];
        REG_CAM_STEP:       cam_step_q      <= pwdata[15:0];
        REG_CAM_MIN:        cam_min_q       <= pwdata[15:0];
        REG_ARM_INTERVAL:   interval_q[0]   <= pwdata[15:0];
        REG_WRIST_INTERVAL: interval_q[1]   <= pwdata[15:0];
        REG_CAM_INTERVAL:   interval_q[2]   <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mov_q       <= '0;
      for (int i = 0; i < NCH; i++) begin
        cur_q[i]   <= '0;
        tgt_q[i]   <= '0;
        ticks_q[i] <= '0;
      end
      for (int i = 0; i < NDUTY; i++) duty_q[i] <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      cur_q   <= cur_d;
      tgt_q   <= tgt_d;
      ticks_q <= ticks_d;
      mov_q   <= mov_d;
      duty_q  <= duty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (work) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i && s1_valid_q))
    else $error("input stalled without a held result beat");

  a_settled_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_data_q.settled_arm || out_data_q.settled_cam))
      |-> (!out_data_q.moving_arm || !out_data_q.settled_arm))
    else $error("settled pulse with moving flag still set");

  a_arm_slew: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (work && s1_q.action == ACT_TICK) |=>
      (cur_q[0] == $past(cur_q[0]) || cur_q[0] == $past(cur_q[0]) + 16'd1 ||
       cur_q[0] == $past(cur_q[0]) - 16'd1))
    else $error("arm duty moved more than one count per tick");

  a_ramp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !work |=> (cur_q[0] == $past(cur_q[0]) && mov_q == $past(mov_q)))
    else $error("ramp state changed without a beat");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the servo slew-rate ramp block: directed table, then random phases.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import svr_pkg::*;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t duty_exp;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_t                in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_t               out_data_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // register mirror and ramp state of the predictor
  logic [15:0]       cfg_regs [8];
  logic [15:0]       cur_duty [NCH];
  logic [15:0]       tgt_duty [NCH];
  logic [TICK_W-1:0] tick_cnt [NCH];
  logic              ramp_moving [NCH];
  logic [15:0]       duty_regs [NDUTY];

  out_t duty_beats_q [$];
  int   fail_cnt = 0;
  bit   tx_burst = 0;
  bit   rx_burst = 0;

  stim_row_t dir_rows [25] = '{
    '{in_t'{ACT_TICK, CH_ARM, 13'd0, 16'sh0}, 1'b1, out_t'('0)},
    '{in_t'{ACT_RAW, CH_AUX, 13'd0, 16'sh8000}, 1'b1,
      out_t'{16'd0, 16'd0, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{in_t'{ACT_RAW, CH_ARM, 13'h1fff, 16'sh7fff}, 1'b1,
      out_t'{16'd32767, 16'd0, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{in_t'{ACT_RAW, CH_WRIST, 13'd0, 16'shffff}, 1'b1,
      out_t'{16'd32767, 16'd1, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{in_t'{ACT_RAW, CH_CAM, 13'd0, 16'sh0}, 1'b1,
      out_t'{16'd32767, 16'd1, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{in_t'{ACT_ANGLE, CH_WRIST, 13'd8191, 16'sh0}, 1'b1,
      out_t'{16'd32767, 16'd0, 16'd0, 16'd32768, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{in_t'{ACT_ANGLE, CH_AUX, 13'd5760, 16'sh0}, 1'b1,
      out_t'{16'd32767, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{in_t'{ACT_ANGLE, CH_ARM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_ANGLE, CH_ARM, 13'd8191, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_ANGLE, CH_CAM, 13'd8191, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TARGET, CH_WRIST, 13'd100, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TARGET, CH_AUX, 13'd100, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TARGET, CH_ARM, 13'd5744, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TARGET, CH_CAM, 13'd1, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_ARM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_WRIST, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_CAM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_AUX, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_ARM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_ARM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TARGET, CH_CAM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_ARM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_ARM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_ARM, 13'd0, 16'sh0}, 1'b0, '0},
    '{in_t'{ACT_TICK, CH_ARM, 13'd0, 16'sh0}, 1'b0, '0}
  };

  servo_slew_rate_ramp_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  function automatic void reset_ramp_model();
    for (int i = 0; i < 8; i++) begin
      cfg_regs[i] = '0;
    end
    cfg_regs[REG_ARM_ANGLE_MAX]  = 16'd180;
    cfg_regs[REG_ARM_INTERVAL]   = 16'd10;
    cfg_regs[REG_WRIST_INTERVAL] = 16'd10;
    cfg_regs[REG_CAM_INTERVAL]   = 16'd10;
    for (int i = 0; i < NCH; i++) begin
      cur_duty[i]    = '0;
      tgt_duty[i]    = '0;
      tick_cnt[i]    = '0;
      ramp_moving[i] = 1'b0;
    end
    for (int i = 0; i < NDUTY; i++) begin
      duty_regs[i] = '0;
    end
  endfunction

  function automatic logic [15:0] angle_to_count(logic [15:0] step, logic [15:0] base,
                                                 logic [12:0] a);
    logic [28:0] prod;
    prod = step * a;
    return prod[ANGLE_FRAC_BITS +: 16] + base;
  endfunction

  function automatic logic [15:0] channel_duty(logic [1:0] ch, logic [12:0] angle);
    logic [12:0] full;
    full = 13'(cfg_regs[REG_ARM_ANGLE_MAX][8:0]) << ANGLE_FRAC_BITS;
    if (ch == CH_ARM) begin
      return angle_to_count(cfg_regs[REG_ARM_STEP], cfg_regs[REG_ARM_MIN],
                            (full > angle) ? full - angle : 13'd0);
    end
    if (ch == CH_CAM) begin
      return angle_to_count(cfg_regs[REG_CAM_STEP], cfg_regs[REG_CAM_MIN], angle);
    end
    return 16'd0;
  endfunction

  function automatic out_t ramp_next(in_t it);
    out_t           r;
    logic [NCH-1:0] settled;
    logic [15:0]    mag;
    settled = '0;
    case (it.action)
      ACT_TICK: begin
        for (int i = 0; i < NCH; i++) begin
          if (tick_cnt[i] < TICK_MAX) tick_cnt[i]++;
          if (cur_duty[i] != tgt_duty[i]) begin
            ramp_moving[i] = 1'b1;
            duty_regs[i] = cur_duty[i];
            if (tick_cnt[i] > {1'b0, cfg_regs[REG_ARM_INTERVAL + i]}) begin
              tick_cnt[i] = '0;
              if (cur_duty[i] < tgt_duty[i]) cur_duty[i]++;
              else cur_duty[i]--;
            end
          end else if (ramp_moving[i]) begin
            ramp_moving[i] = 1'b0;
            settled[i] = 1'b1;
          end
        end
      end
      ACT_TARGET: begin
        if (it.channel == CH_ARM || it.channel == CH_CAM) begin
          tgt_duty[it.channel] = channel_duty(it.channel, it.angle);
          tick_cnt[it.channel] = '0;
        end
      end
      ACT_ANGLE: begin
        duty_regs[it.channel] = channel_duty(it.channel, it.angle);
      end
      default: begin
        mag = it.raw_value[15] ? (~it.raw_value + 16'd1) : it.raw_value;
        duty_regs[it.channel] = mag;
      end
    endcase
    r.duty_arm      = duty_regs[CH_ARM];
    r.duty_wrist    = duty_regs[CH_WRIST];
    r.duty_cam      = duty_regs[CH_CAM];
    r.duty_aux      = duty_regs[CH_AUX];
    r.moving_arm    = ramp_moving[CH_ARM];
    r.moving_wrist  = ramp_moving[CH_WRIST];
    r.moving_cam    = ramp_moving[CH_CAM];
    r.settled_arm   = settled[CH_ARM];
    r.settled_wrist = settled[CH_WRIST];
    r.settled_cam   = settled[CH_CAM];
    return r;
  endfunction

  task automatic flag_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_cnt++;
    end
  endtask

  task automatic apb_write(logic [2:0] idx, logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    cfg_regs[idx] = (idx == REG_ARM_ANGLE_MAX) ? {7'd0, val[8:0]} : val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all(logic [15:0] arm_step, logic [15:0] arm_min,
                           logic [15:0] angle_max, logic [15:0] cam_step,
                           logic [15:0] cam_min, logic [15:0] arm_iv,
                           logic [15:0] wrist_iv, logic [15:0] cam_iv);
    apb_write(REG_ARM_STEP, arm_step);
    apb_write(REG_ARM_MIN, arm_min);
    apb_write(REG_ARM_ANGLE_MAX, angle_max);
    apb_write(REG_CAM_STEP, cam_step);
    apb_write(REG_CAM_MIN, cam_min);
    apb_write(REG_ARM_INTERVAL, arm_iv);
    apb_write(REG_WRIST_INTERVAL, wrist_iv);
    apb_write(REG_CAM_INTERVAL, cam_iv);
  endtask

  task automatic send_beat(in_t it, bit typed, out_t typed_exp);
    int   gap;
    out_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 23) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pred = ramp_next(it);
    duty_beats_q.push_back(typed ? typed_exp : pred);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (duty_beats_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(int beats);
    in_t         it;
    int          counted;
    int          pick;
    int          k;
    logic [12:0] full;
    counted = 0;
    while (counted < beats) begin
      pick = $urandom_range(0, 99);
      it.channel   = 2'($urandom_range(0, 3));
      it.raw_value = 16'($urandom);
      it.angle     = 13'($urandom_range(0, 8191));
      if (pick < 55) begin
        it.action = ACT_TICK;
      end else if (pick < 72) begin
        it.action = ACT_TARGET;
        if ($urandom_range(0, 3) != 0) it.channel = $urandom_range(0, 1) ? CH_ARM : CH_CAM;
      end else if (pick < 82) begin
        it.action = ACT_ANGLE;
      end else begin
        it.action = ACT_RAW;
      end
      // keep most targets close so ramps finish and settle
      if (it.action != ACT_RAW && $urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, 63);
        full = 13'(cfg_regs[REG_ARM_ANGLE_MAX][8:0]) << ANGLE_FRAC_BITS;
        it.angle = (it.channel == CH_ARM && full >= 13'(k)) ? full - 13'(k) : 13'(k);
      end
      if ($urandom_range(0, 15) == 0) it.raw_value = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
      send_beat(it, 1'b0, '0);
      if (!(it.action == ACT_TARGET && (it.channel == CH_WRIST || it.channel == CH_AUX))) begin
        counted++;
      end
    end
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk_i) begin
    out_t want;
    if (out_valid_o && !out_stall_i) begin
      if (duty_beats_q.size() == 0) begin
        $error("result beat with nothing expected: %p", out_data_o);
        fail_cnt++;
      end else begin
        want = duty_beats_q.pop_front();
        flag_field("duty_arm", want.duty_arm, out_data_o.duty_arm);
        flag_field("duty_wrist", want.duty_wrist, out_data_o.duty_wrist);
        flag_field("duty_cam", want.duty_cam, out_data_o.duty_cam);
        flag_field("duty_aux", want.duty_aux, out_data_o.duty_aux);
        flag_field("moving_arm", want.moving_arm, out_data_o.moving_arm);
        flag_field("moving_wrist", want.moving_wrist, out_data_o.moving_wrist);
        flag_field("moving_cam", want.moving_cam, out_data_o.moving_cam);
        flag_field("settled_arm", want.settled_arm, out_data_o.settled_arm);
        flag_field("settled_wrist", want.settled_wrist, out_data_o.settled_wrist);
        flag_field("settled_cam", want.settled_cam, out_data_o.settled_cam);
      end
    end
  end

  initial begin
    int hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = rx_burst ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 23) == 0) rx_burst = !rx_burst;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o || out_stall_i);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    reset_ramp_model();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_all(16'd2, 16'd3, 16'd360, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd1);
    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].duty_exp);
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(16'hffff, 16'hffff, 16'd360, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     16'hffff);
        1: write_all('0, '0, '0, '0, '0, '0, '0, '0);
        default: write_all(16'($urandom_range(0, 12)), 16'($urandom_range(0, 30)),
                           (ph == 2) ? 16'd511 : 16'($urandom_range(0, 360)),
                           16'($urandom_range(0, 12)), 16'($urandom_range(0, 30)),
                           16'($urandom_range(0, 2)), 16'($urandom),
                           16'($urandom_range(0, 2)));
      endcase
      run_phase(192);
    end

    repeat (6) @(posedge clk_i);
    if (fail_cnt == 0 && duty_beats_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
